@@ src/fpdgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy PD gain scheduler package
// Shared constants, rule and gear tables, register indexes and the
// elaboration-time membership threshold table.
// ----------------------------------------------------------------------------
package fpdgs_pkg;

   localparam int NORM_FRAC_BITS_DEF = 4;
   localparam int NUM_SETS           = 7;
   localparam int NUM_LEVELS         = 50;

   localparam logic [9:0] ERROR_LIMIT_RST = 10'd130;
   localparam logic [9:0] RATE_LIMIT_RST  = 10'd65;
   localparam logic [9:0] OMEGA_LIMIT_RST = 10'd10;

   typedef enum logic [2:0] {
      CSR_ERROR_LIMIT = 3'd0,
      CSR_RATE_LIMIT  = 3'd1,
      CSR_OMEGA_LIMIT = 3'd2,
      CSR_P_GEAR      = 3'd3,
      CSR_D_GEAR      = 3'd4
   } csr_index_type;

   typedef logic [2:0]  label_type;
   typedef logic [10:0] gain_type;
   typedef logic [31:0] thr_arr_type [NUM_LEVELS];

   // Node positions shifted by +50, so that they compare against the
   // unsigned scaled value directly.
   localparam int NODE_Q_BASE [NUM_SETS] = '{5, 20, 35, 50, 65, 80, 95};

   localparam gain_type P_TAB [4][NUM_SETS] = '{
      '{11'd700,  11'd680,  11'd550, 11'd450, 11'd550, 11'd680,  11'd700},
      '{11'd1200, 11'd1000, 11'd800, 11'd600, 11'd800, 11'd1000, 11'd1200},
      '{11'd1000, 11'd900,  11'd800, 11'd700, 11'd800, 11'd900,  11'd1000},
      '{11'd1150, 11'd1000, 11'd850, 11'd700, 11'd850, 11'd1000, 11'd1150}};

   localparam gain_type D_TAB [3][NUM_SETS] = '{
      '{11'd2000, 11'd1700, 11'd1450, 11'd1200, 11'd1450, 11'd1700, 11'd2000},
      '{11'd240,  11'd160,  11'd80,   11'd0,    11'd80,   11'd160,  11'd240},
      '{11'd200,  11'd190,  11'd140,  11'd100,  11'd140,  11'd190,  11'd200}};

   localparam label_type P_RULES [NUM_SETS][NUM_SETS] = '{
      '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3},
      '{3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
      '{3'd5, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2},
      '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
      '{3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
      '{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
      '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0}};

   localparam label_type D_RULES [NUM_SETS][NUM_SETS] = '{
      '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
      '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3},
      '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
      '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5},
      '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6},
      '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6},
      '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6}};

   function automatic label_type rule_label(input logic kind, input logic [2:0] row,
                                            input logic [2:0] col);
      return kind ? D_RULES[row][col] : P_RULES[row][col];
   endfunction

   // Entry m holds floor(100*ln(50/(m+1))*4^frac). A distance of i fine
   // steps has a membership of at least m+1 when 3*i*i does not exceed it.
   // Evaluated at elaboration only.
   function automatic thr_arr_type thr_table(input int frac);
      thr_arr_type t;
      real r;
      for (int m = 0; m < NUM_LEVELS; m++) begin
         r = 100.0 * ($ln(50.0) - $ln(real'(m + 1))) * (2.0 ** (2 * frac));
         t[m] = 32'($rtoi(r));
      end
      return t;
   endfunction

endpackage
`default_nettype wire

@@ src/fpdgs_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, several lanes in lockstep, with a
// sideband word and a per-stage valid/ready chain.
// ----------------------------------------------------------------------------
module fpdgs_div_pipe #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 19,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 11,
   parameter int SIDE_W = 1
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  wire  [LANES-1:0][NUM_W-1:0]       in_num,
   input  wire  [LANES-1:0][DEN_W-1:0]       in_den,
   input  wire  [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   input  wire                               out_ready,
   output logic [LANES-1:0][QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int STAGES = QUO_W;
   localparam int CW     = NUM_W + QUO_W;

   logic [STAGES-1:0]                  v_ff;
   logic [STAGES:0]                    en;
   logic [LANES-1:0][NUM_W-1:0]        rem_ff  [STAGES-1];
   logic [LANES-1:0][DEN_W-1:0]        den_ff  [STAGES];
   logic [LANES-1:0][QUO_W-1:0]        quo_ff  [STAGES];
   logic [SIDE_W-1:0]                  side_ff [STAGES];

   assign en[STAGES] = out_ready;
   assign in_ready   = en[0];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                          v_src;
      logic [LANES-1:0][NUM_W-1:0]   rem_src;
      logic [LANES-1:0][DEN_W-1:0]   den_src;
      logic [LANES-1:0][QUO_W-1:0]   quo_src;
      logic [SIDE_W-1:0]             side_src;
      logic [LANES-1:0]              take;
      logic [LANES-1:0][CW-1:0]      shifted;
      logic [LANES-1:0][QUO_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_num;
         assign den_src  = in_den;
         assign quo_src  = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign en[k] = ~v_ff[k] | en[k+1];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            shifted[l] = CW'(den_src[l]) << (QUO_W - 1 - k);
            take[l]    = CW'(rem_src[l]) >= shifted[l];
            quo_in[l]  = quo_src[l];
            quo_in[l][QUO_W-1-k] = take[l];
         end
      end

      if (k < STAGES - 1) begin : g_rem
         logic [LANES-1:0][NUM_W-1:0] rem_in;

         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_in[l] = take[l] ? NUM_W'(CW'(rem_src[l]) - shifted[l]) : rem_src[l];
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k] <= rem_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            den_ff[k]  <= den_src;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
`default_nettype wire

@@ src/fuzzy_pd_gain_scheduler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy PD gain scheduler
// Clamps and scales two inputs, fuzzifies them with Gaussian memberships,
// fires four rules of a 7x7 table and returns the weighted average gain.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one beat per gain request: kind in tuser, error_in and
//   second_in in tdata. rsp_ returns one beat per request, in order, with the
//   gain times 100 in tdata and the no-rule flag in tuser.
//   csr_ writes the limit and gear registers; it is always ready and must only
//   be used while no request is in flight.
// The pipeline holds one input stage, the normalizing divider with one
// stage per quotient bit, seven fuzzy stages and an 11-stage averaging
// divider. Throughput is one beat per cycle while rsp_tready stays high.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up and a stalled rsp_tready
// holds the results in place without loss. Reset empties the pipeline and
// restores the register defaults.
// ----------------------------------------------------------------------------
module fuzzy_pd_gain_scheduler_unit #(
   parameter int NORM_FRAC_BITS = fpdgs_pkg::NORM_FRAC_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // error_in [10:0], second_in [21:11], zero pad
   input  wire  [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // gain_x100 [10:0], zero pad
   output logic [0:0]  rsp_tuser,   // no_rule
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [9:0]  csr_data
);

   localparam int SCALE = 1 << NORM_FRAC_BITS;
   localparam int QW    = $clog2(100 * SCALE + 1);
   localparam int MULW  = $clog2(50 * SCALE + 1);
   localparam int NW    = 11 + MULW;
   localparam int DW    = $clog2(15 * SCALE + 1);
   localparam int SQW   = 2 * DW;
   localparam int LV    = fpdgs_pkg::NUM_LEVELS;
   localparam fpdgs_pkg::thr_arr_type THR = fpdgs_pkg::thr_table(NORM_FRAC_BITS);

   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_LOW  = 2'd1,
      OUT_HIGH = 2'd2
   } outer_type;

   typedef struct packed {
      logic [2:0]    seg;
      outer_type     outer;
      logic [DW-1:0] dlo;
      logic [DW-1:0] dhi;
   } fuzz_type;

   // ---------------- configuration registers ----------------
   logic [9:0] error_limit_ff, rate_limit_ff, omega_limit_ff;
   logic [1:0] p_gear_ff, d_gear_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= fpdgs_pkg::ERROR_LIMIT_RST;
         rate_limit_ff  <= fpdgs_pkg::RATE_LIMIT_RST;
         omega_limit_ff <= fpdgs_pkg::OMEGA_LIMIT_RST;
         p_gear_ff      <= 2'd0;
         d_gear_ff      <= 2'd0;
      end else if (csr_valid) begin
         unique case (fpdgs_pkg::csr_index_type'(csr_index))
            fpdgs_pkg::CSR_ERROR_LIMIT: error_limit_ff <= csr_data;
            fpdgs_pkg::CSR_RATE_LIMIT:  rate_limit_ff  <= csr_data;
            fpdgs_pkg::CSR_OMEGA_LIMIT: omega_limit_ff <= csr_data;
            fpdgs_pkg::CSR_P_GEAR:      p_gear_ff      <= csr_data[1:0];
            fpdgs_pkg::CSR_D_GEAR:      d_gear_ff      <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // ---------------- helpers ----------------
   // Clamp to +-lim and shift by lim, giving 0..2*lim.
   function automatic logic [10:0] clamp_shift(input logic [10:0] v, input logic [9:0] lim);
      logic signed [11:0] vs, ls, sum;
      vs = 12'(signed'(v));
      ls = signed'({2'b00, lim});
      if (vs > ls) begin
         vs = ls;
      end else if (vs < -ls) begin
         vs = -ls;
      end
      sum = vs + ls;
      return sum[10:0];
   endfunction

   function automatic logic [QW-1:0] node_q(input int j);
      return QW'(fpdgs_pkg::NODE_Q_BASE[j] * SCALE);
   endfunction

   function automatic fuzz_type fuzzify(input logic [QW-1:0] q);
      fuzz_type f;
      logic     found;
      f     = '{seg: 3'd6, outer: OUT_NONE, dlo: '0, dhi: '0};
      found = 1'b0;
      if (q <= node_q(0)) begin
         f.seg   = 3'd1;
         f.outer = OUT_LOW;
      end else if (q >= node_q(fpdgs_pkg::NUM_SETS - 1)) begin
         f.outer = OUT_HIGH;
      end else begin
         for (int k = 1; k < fpdgs_pkg::NUM_SETS - 1; k++) begin
            if (!found && q <= node_q(k)) begin
               found = 1'b1;
               f.seg = 3'(k);
            end
         end
         for (int k = 1; k < fpdgs_pkg::NUM_SETS; k++) begin
            if (f.seg == 3'(k)) begin
               f.dlo = DW'(q - node_q(k - 1));
               f.dhi = DW'(node_q(k) - q);
            end
         end
      end
      return f;
   endfunction

   // ---------------- stage A: clamp and scale numerator ----------------
   logic                       en_a, a_v_ff, a_kind_ff;
   logic [1:0][NW-1:0]         a_num_ff;
   logic [1:0][9:0]            a_den_ff;
   logic [9:0]                 lim_e, lim_c, lim_c_raw;
   logic [10:0]                x_e, x_c;

   always_comb begin
      lim_c_raw = req_tuser[0] ? omega_limit_ff : rate_limit_ff;
      lim_e     = (error_limit_ff == 10'd0) ? 10'd1 : error_limit_ff;
      lim_c     = (lim_c_raw == 10'd0) ? 10'd1 : lim_c_raw;
      x_e       = clamp_shift(req_tdata[10:0], lim_e);
      x_c       = clamp_shift(req_tdata[21:11], lim_c);
   end

   logic d1_in_ready, d1_out_valid;
   logic [1:0][QW-1:0] d1_quo;
   logic [0:0]         d1_side;
   logic en_b, en_c, en_d, en_e, en_f, en_g, en_h;

   assign en_a       = ~a_v_ff | d1_in_ready;
   assign req_tready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en_a) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_kind_ff   <= req_tuser[0];
         a_num_ff[0] <= NW'(x_e) * NW'(50 * SCALE);
         a_num_ff[1] <= NW'(x_c) * NW'(50 * SCALE);
         a_den_ff[0] <= lim_e;
         a_den_ff[1] <= lim_c;
      end
   end

   fpdgs_div_pipe #(
      .LANES (2),
      .NUM_W (NW),
      .DEN_W (10),
      .QUO_W (QW),
      .SIDE_W(1)
   ) u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_v_ff),
      .in_ready (d1_in_ready),
      .in_num   (a_num_ff),
      .in_den   (a_den_ff),
      .in_side  (a_kind_ff),
      .out_valid(d1_out_valid),
      .out_ready(en_b),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // ---------------- stage B: segment and distances ----------------
   logic             b_v_ff, b_kind_ff;
   fuzz_type [1:0]   b_fz_ff;

   assign en_b = ~b_v_ff | en_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en_b) begin
         b_v_ff <= d1_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_kind_ff  <= d1_side[0];
         b_fz_ff[0] <= fuzzify(d1_quo[0]);
         b_fz_ff[1] <= fuzzify(d1_quo[1]);
      end
   end

   // ---------------- stage C: squared distances ----------------
   logic                        c_v_ff, c_kind_ff;
   logic [1:0][2:0]             c_seg_ff;
   outer_type [1:0]             c_outer_ff;
   logic [1:0][1:0][SQW-1:0]    c_sq_ff;

   assign en_c = ~c_v_ff | en_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_kind_ff <= b_kind_ff;
         for (int ch = 0; ch < 2; ch++) begin
            c_seg_ff[ch]    <= b_fz_ff[ch].seg;
            c_outer_ff[ch]  <= b_fz_ff[ch].outer;
            c_sq_ff[ch][0]  <= SQW'(b_fz_ff[ch].dlo) * SQW'(b_fz_ff[ch].dlo);
            c_sq_ff[ch][1]  <= SQW'(b_fz_ff[ch].dhi) * SQW'(b_fz_ff[ch].dhi);
         end
      end
   end

   // ---------------- stage D: threshold compares ----------------
   logic                        d_v_ff, d_kind_ff;
   logic [1:0][2:0]             d_seg_ff;
   outer_type [1:0]             d_outer_ff;
   logic [1:0][1:0][LV-1:0]     d_thermo_ff;

   assign en_d = ~d_v_ff | en_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en_d) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_kind_ff  <= c_kind_ff;
         d_seg_ff   <= c_seg_ff;
         d_outer_ff <= c_outer_ff;
         for (int ch = 0; ch < 2; ch++) begin
            for (int s = 0; s < 2; s++) begin
               for (int m = 0; m < LV; m++) begin
                  d_thermo_ff[ch][s][m] <= ((32'(c_sq_ff[ch][s]) * 32'd3) <= THR[m]);
               end
            end
         end
      end
   end

   // ---------------- stage E: memberships and rule labels ----------------
   logic                               e_v_ff, e_kind_ff;
   logic [1:0][1:0][5:0]               e_mu_ff;
   fpdgs_pkg::label_type [3:0]         e_lab_ff;
   logic [1:0][1:0][5:0]               mu_in;
   fpdgs_pkg::label_type [3:0]         lab_in;
   logic [2:0]                         se, sc;

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         for (int s = 0; s < 2; s++) begin
            mu_in[ch][s] = 6'd0;
            for (int m = 0; m < LV; m++) begin
               mu_in[ch][s] = mu_in[ch][s] + 6'(d_thermo_ff[ch][s][m]);
            end
         end
         if (d_outer_ff[ch] == OUT_LOW) begin
            mu_in[ch][0] = 6'd50;
            mu_in[ch][1] = 6'd0;
         end else if (d_outer_ff[ch] == OUT_HIGH) begin
            mu_in[ch][0] = 6'd0;
            mu_in[ch][1] = 6'd50;
         end
      end
      se        = d_seg_ff[0];
      sc        = d_seg_ff[1];
      lab_in[0] = fpdgs_pkg::rule_label(d_kind_ff, se - 3'd1, sc - 3'd1);
      lab_in[1] = fpdgs_pkg::rule_label(d_kind_ff, se,        sc - 3'd1);
      lab_in[2] = fpdgs_pkg::rule_label(d_kind_ff, se - 3'd1, sc);
      lab_in[3] = fpdgs_pkg::rule_label(d_kind_ff, se,        sc);
   end

   assign en_e = ~e_v_ff | en_f;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en_e) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_kind_ff <= d_kind_ff;
         e_mu_ff   <= mu_in;
         e_lab_ff  <= lab_in;
      end
   end

   // ---------------- stage F: rule weights, one per output label ----------------
   logic                               f_v_ff, f_kind_ff;
   logic [3:0][5:0]                    f_w_ff;
   fpdgs_pkg::label_type [3:0]         f_lab_ff;
   logic [3:0][5:0]                    w_in;

   function automatic logic [5:0] min6(input logic [5:0] a, input logic [5:0] b);
      return (a < b) ? a : b;
   endfunction

   always_comb begin
      w_in[0] = min6(e_mu_ff[0][0], e_mu_ff[1][0]);
      w_in[1] = min6(e_mu_ff[0][1], e_mu_ff[1][0]);
      w_in[2] = min6(e_mu_ff[0][0], e_mu_ff[1][1]);
      w_in[3] = min6(e_mu_ff[0][1], e_mu_ff[1][1]);
      // Pairs in order (0,1) (0,2) (0,3) (1,2) (1,3) (2,3); the earlier
      // weight loses a tie.
      for (int a = 0; a < 3; a++) begin
         for (int b = a + 1; b < 4; b++) begin
            if (e_lab_ff[a] == e_lab_ff[b]) begin
               if (w_in[a] > w_in[b]) begin
                  w_in[b] = 6'd0;
               end else begin
                  w_in[a] = 6'd0;
               end
            end
         end
      end
   end

   assign en_f = ~f_v_ff | en_g;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en_f) begin
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         f_kind_ff <= e_kind_ff;
         f_w_ff    <= w_in;
         f_lab_ff  <= e_lab_ff;
      end
   end

   // ---------------- stage G: gear table products ----------------
   logic                  g_v_ff;
   logic [3:0][16:0]      g_prod_ff;
   logic [3:0][5:0]       g_w_ff;
   logic [1:0]            d_sel;
   fpdgs_pkg::gain_type [3:0] tab_val;

   always_comb begin
      d_sel = (d_gear_ff == 2'd3) ? 2'd2 : d_gear_ff;
      for (int i = 0; i < 4; i++) begin
         tab_val[i] = f_kind_ff ? fpdgs_pkg::D_TAB[d_sel][f_lab_ff[i]]
                                : fpdgs_pkg::P_TAB[p_gear_ff][f_lab_ff[i]];
      end
   end

   assign en_g = ~g_v_ff | en_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en_g) begin
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_g) begin
         g_w_ff <= f_w_ff;
         for (int i = 0; i < 4; i++) begin
            g_prod_ff[i] <= 17'(f_w_ff[i]) * 17'(tab_val[i]);
         end
      end
   end

   // ---------------- stage H: sums ----------------
   logic         h_v_ff;
   logic [18:0]  h_num_ff;
   logic [7:0]   h_den_ff;
   logic         d2_in_ready, d2_out_valid;
   logic [0:0][10:0] d2_quo;
   logic [0:0]   d2_side;

   assign en_h = ~h_v_ff | d2_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else if (en_h) begin
         h_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         h_num_ff <= 19'(g_prod_ff[0]) + 19'(g_prod_ff[1])
                   + 19'(g_prod_ff[2]) + 19'(g_prod_ff[3]);
         h_den_ff <= 8'(g_w_ff[0]) + 8'(g_w_ff[1]) + 8'(g_w_ff[2]) + 8'(g_w_ff[3]);
      end
   end

   fpdgs_div_pipe #(
      .LANES (1),
      .NUM_W (19),
      .DEN_W (8),
      .QUO_W (11),
      .SIDE_W(1)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (h_v_ff),
      .in_ready (d2_in_ready),
      .in_num   (h_num_ff),
      .in_den   (h_den_ff),
      .in_side  (h_den_ff == 8'd0),
      .out_valid(d2_out_valid),
      .out_ready(rsp_tready),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // A zero weight sum leaves an all-ones quotient, which is masked here.
   assign rsp_tvalid = d2_out_valid;
   assign rsp_tuser  = d2_side;
   assign rsp_tdata  = {5'd0, d2_side[0] ? 11'd0 : d2_quo[0]};

`ifndef SYNTHESIS
   a_no_rule_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("no_rule result carries a nonzero gain");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:0] <= 11'd2000)
      else $error("gain above the largest table entry");

   a_label_unique: assert property (@(posedge clock) disable iff (reset)
      f_v_ff |-> !((f_w_ff[0] != 0 && f_w_ff[1] != 0 && f_lab_ff[0] == f_lab_ff[1]) ||
                   (f_w_ff[0] != 0 && f_w_ff[2] != 0 && f_lab_ff[0] == f_lab_ff[2]) ||
                   (f_w_ff[0] != 0 && f_w_ff[3] != 0 && f_lab_ff[0] == f_lab_ff[3]) ||
                   (f_w_ff[1] != 0 && f_w_ff[2] != 0 && f_lab_ff[1] == f_lab_ff[2]) ||
                   (f_w_ff[1] != 0 && f_w_ff[3] != 0 && f_lab_ff[1] == f_lab_ff[3]) ||
                   (f_w_ff[2] != 0 && f_w_ff[3] != 0 && f_lab_ff[2] == f_lab_ff[3])))
      else $error("two surviving rules share an output label");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      h_v_ff |-> h_den_ff <= 8'd200)
      else $error("weight sum exceeds four full memberships");
`endif

endmodule
`default_nettype wire
